// ===== rtl/core/led_panel_quarter_scan_driver_assert.svh =====
// assertion macros for the led panel quarter scan driver
`ifndef LED_PANEL_QUARTER_SCAN_DRIVER_ASSERT_SVH
`define LED_PANEL_QUARTER_SCAN_DRIVER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LPQS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define LPQS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/lpqs_pkg.sv =====
// types and constants shared by the led panel quarter scan driver
`timescale 1ns / 1ps
package lpqs_pkg;

   localparam int AddrWidth = 6;

   localparam logic CMD_PIXEL   = 1'b0;
   localparam logic CMD_REFRESH = 1'b1;

   localparam logic [7:0] PanelWidth  = 8'd32;
   localparam logic [7:0] PanelHeight = 8'd16;
   localparam logic [7:0] MaskMsb     = 8'h80;
   localparam logic [3:0] GroupLastPos = 4'hF;
   localparam logic [AddrWidth-1:0] LastByte = '1;

   typedef logic [AddrWidth-1:0] addr_type;

   typedef struct packed {
      logic     rd_en;
      logic     wr_en;
      addr_type addr;
      logic [7:0] wr_data;
   } mem_req_type;

   typedef struct packed {
      logic       latch_before;
      logic       latch_after;
      logic [1:0] row_select;
      logic       last;
   } scan_flags_type;

endpackage

// ===== rtl/core/lpqs_chan_if.sv =====
// valid/ready channel interfaces for pixel/refresh requests and scan bytes
`timescale 1ns / 1ps
interface lpqs_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] x;
   logic [7:0] y;
   logic       color;

   modport source (output valid, output cmd, output x, output y, output color, input ready);
   modport sink (input valid, input cmd, input x, input y, input color, output ready);
endinterface

interface lpqs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] shift_byte;
   logic       latch_before;
   logic       latch_after;
   logic [1:0] row_select;
   logic       last;

   modport source (output valid, output shift_byte, output latch_before,
                   output latch_after, output row_select, output last, input ready);
   modport sink (input valid, input shift_byte, input latch_before,
                 input latch_after, input row_select, input last, output ready);
endinterface

// ===== rtl/core/lpqs_frame_mem.sv =====
// 64-byte frame store with per-entry valid bits and registered read
`timescale 1ns / 1ps
module lpqs_frame_mem
   import lpqs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mem_req_type mem_req,
   output logic [7:0]  rd_data
);

   localparam int Depth = 2 ** AddrWidth;

   logic [7:0]       mem_ff [Depth];
   logic [Depth-1:0] valid_ff;
   logic [7:0]       rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= valid_ff[mem_req.addr] ? mem_ff[mem_req.addr] : 8'h00;
      end
   end

   // unwritten entries read as dark
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (mem_req.wr_en) begin
         valid_ff[mem_req.addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/lpqs_addr_unit.sv =====
// shared address unit: pixel byte/mask and scan order byte with markers
`timescale 1ns / 1ps
module lpqs_addr_unit
   import lpqs_pkg::*;
(
   input  logic           scan_mode,
   input  logic [7:0]     x,
   input  logic [7:0]     y,
   input  addr_type       count,
   output addr_type       addr,
   output logic [7:0]     mask,
   output logic           in_range,
   output scan_flags_type flags
);

   logic group_end;

   always_comb begin
      in_range  = (x < PanelWidth) && (y < PanelHeight);
      mask      = MaskMsb >> x[2:0];
      group_end = (count[3:0] == GroupLastPos);
      if (scan_mode) begin
         // half, block (24,16,8,0), row group, column
         addr = {count[3], ~count[1:0], count[5:4], count[2]};
      end else begin
         addr = {x[4], y[3:0], x[3]};
      end
      flags.latch_before = (count == '0);
      flags.latch_after  = group_end;
      flags.row_select   = group_end ? count[5:4] : 2'd0;
      flags.last         = (count == LastByte);
   end

endmodule

// ===== rtl/core/led_panel_quarter_scan_driver.sv =====
// top level of the led panel quarter scan driver
//
// req_chan (sink): one command per transfer. cmd = pixel write sets or
// clears the bit at (x, y) of the 64-byte frame store; writes with x >= 32
// or y >= 16 are dropped. cmd = refresh streams the whole store.
// rsp_chan (source): one inverted frame byte per transfer, MSB first on the
// panel data pin, with latch_before on the first byte, latch_after and
// row_select on the sixteenth byte of each row group, and last on byte 64.
// a pixel write reads the addressed byte on accept, then merges and writes
// it back in PIX_WR through the single store port; a dropped write leaves
// the sequencer idle. a refresh issues the registered store read of each
// byte in SCAN_RD and loads it into the output register in SCAN_LD. when
// rsp ready is low the byte waits in the output register and the scan
// pauses. the next command is accepted as soon as the last byte is loaded,
// even while it still waits to be taken.
// reset (synchronous) clears the frame store to dark via its valid bits,
// empties the output register and returns the sequencer to idle.
`timescale 1ns / 1ps
`include "led_panel_quarter_scan_driver_assert.svh"
module led_panel_quarter_scan_driver
   import lpqs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   lpqs_req_if.sink   req_chan,
   lpqs_rsp_if.source rsp_chan
);

   typedef enum logic [1:0] {
      IDLE,
      PIX_WR,
      SCAN_RD,
      SCAN_LD
   } state_type;

   state_type      state_ff;
   addr_type       count_ff;
   addr_type       pix_addr_ff;
   logic [7:0]     pix_mask_ff;
   logic           pix_color_ff;
   logic           out_valid_ff;
   logic [7:0]     out_byte_ff;
   scan_flags_type out_flags_ff;

   logic           req_accept;
   logic           out_load;
   mem_req_type    mem_req;
   logic [7:0]     rd_data;
   addr_type       unit_addr;
   logic [7:0]     unit_mask;
   logic           unit_in_range;
   scan_flags_type unit_flags;

   lpqs_addr_unit u_addr (
      .scan_mode (state_ff != IDLE),
      .x         (req_chan.x),
      .y         (req_chan.y),
      .count     (count_ff),
      .addr      (unit_addr),
      .mask      (unit_mask),
      .in_range  (unit_in_range),
      .flags     (unit_flags)
   );

   lpqs_frame_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign req_chan.ready = (state_ff == IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign out_load       = (state_ff == SCAN_LD) && (!out_valid_ff || rsp_chan.ready);

   always_comb begin
      mem_req      = '0;
      mem_req.addr = unit_addr;
      case (state_ff)
         IDLE: begin
            mem_req.rd_en = req_accept && (req_chan.cmd == CMD_PIXEL) && unit_in_range;
         end
         PIX_WR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.addr    = pix_addr_ff;
            mem_req.wr_data = pix_color_ff ? (rd_data | pix_mask_ff)
                                           : (rd_data & ~pix_mask_ff);
         end
         SCAN_RD: begin
            mem_req.rd_en = 1'b1;
         end
         default: begin
            mem_req.rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            IDLE: begin
               if (req_accept) begin
                  if (req_chan.cmd == CMD_REFRESH) begin
                     count_ff <= '0;
                     state_ff <= SCAN_RD;
                  end else if (unit_in_range) begin
                     state_ff <= PIX_WR;
                  end
               end
            end
            PIX_WR: begin
               state_ff <= IDLE;
            end
            SCAN_RD: begin
               state_ff <= SCAN_LD;
            end
            SCAN_LD: begin
               if (out_load) begin
                  count_ff <= count_ff + 1'b1;
                  state_ff <= unit_flags.last ? IDLE : SCAN_RD;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase

         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         pix_addr_ff  <= unit_addr;
         pix_mask_ff  <= unit_mask;
         pix_color_ff <= req_chan.color;
      end
      if (out_load) begin
         out_byte_ff  <= ~rd_data;
         out_flags_ff <= unit_flags;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.shift_byte   = out_byte_ff;
   assign rsp_chan.latch_before = out_flags_ff.latch_before;
   assign rsp_chan.latch_after  = out_flags_ff.latch_after;
   assign rsp_chan.row_select   = out_flags_ff.row_select;
   assign rsp_chan.last         = out_flags_ff.last;

   `LPQS_ASSERT_NOW(a_last_wraps_count, clock, reset,
      out_valid_ff && out_flags_ff.last && (state_ff != SCAN_LD), count_ff == '0,
      "scan counter not wrapped after last byte")
   `LPQS_ASSERT_NEXT(a_refresh_starts_scan, clock, reset,
      req_accept && (req_chan.cmd == CMD_REFRESH), (state_ff == SCAN_RD) && (count_ff == '0),
      "refresh did not start scan at byte zero")
   `LPQS_ASSERT_NEXT(a_load_fills_output, clock, reset,
      out_load, out_valid_ff,
      "scan byte loaded but output not valid")

endmodule
